>>> rtl/prpp_pkg.sv
// ----------------------------------------------------------------------------
// prpp_pkg
// Shared constants for the piecewise ramp profile player: operation codes,
// fixed field widths, register map and parameter defaults.
// ----------------------------------------------------------------------------
package prpp_pkg;

   // parameter defaults
   localparam int MAX_SEGMENTS_DEFAULT = 16;
   localparam int TICK_BITS_DEFAULT    = 24;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int DUR_W   = 24;
   localparam int LEVEL_W = 17;
   localparam int PWM_W   = 16;
   localparam int ACC_W   = 34;   // signed Q18.16 level / delta
   localparam int MAG_W   = 32;   // dividend: level difference << 16
   localparam int PROD_W  = LEVEL_W + PWM_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_RAMP    = 2'd0;
   localparam logic [OP_W-1:0] OP_HOLD    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FULL_SCALE = 1'b0;   // register index, paddr[2]
   localparam logic [PWM_W-1:0] FULL_SCALE_RESET = 16'd255;

   // level 1.0 in Q1.16
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;
   // one half in Q0.16
   localparam logic [PWM_W-1:0] HALF_Q16 = 16'h8000;

endpackage

>>> rtl/prpp_ram.sv
// ----------------------------------------------------------------------------
// prpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/piecewise_ramp_profile_player_top.sv
// ----------------------------------------------------------------------------
// piecewise_ramp_profile_player_top
// Segment table plus playback engine for a piecewise linear PWM speed profile.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result beat
// shows on the rsp_ ports for one cycle with rsp_strobe high and cannot be
// stalled. Append ramp runs through one multiply, rounding, difference, then 32
// restoring-division steps through the shared subtractor, then the table write;
// append hold to the table write; a timer tick through table read, accumulate
// and round. Restart, refused appends and ticks on an exhausted profile strobe
// straight from idle. busy stays high until the strobe cycle, in which the next
// item may already be taken. The segment table is one RAM; its entries are
// undefined until appended and only entries below the fill count are read.
// ----------------------------------------------------------------------------
module piecewise_ramp_profile_player_top
   import prpp_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT,
   parameter int TICK_BITS    = TICK_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [DUR_W-1:0]      req_duration_ticks,
   input  logic [LEVEL_W-1:0]    req_target_level,
   // result channel
   output logic                  rsp_strobe,
   output logic [PWM_W-1:0]      rsp_pwm_value,
   output logic                  rsp_value_valid,
   output logic                  rsp_profile_done,
   output logic                  rsp_accepted,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int DCNT_W = $clog2(MAG_W);
   localparam int ENT_W  = ACC_W + TICK_BITS;
   localparam logic [CNT_W-1:0]  SEG_LIMIT = CNT_W'(MAX_SEGMENTS);
   localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(MAG_W - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_FIN   = 3'd2;
   localparam logic [2:0] ST_DIFF  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_TACC  = 3'd6;
   localparam logic [2:0] ST_TOUT  = 3'd7;

   // control state
   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   write_count_ff, write_count_in;
   logic [CNT_W-1:0]   play_index_ff, play_index_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [PWM_W-1:0]   last_final_ff, last_final_in;
   logic [PWM_W-1:0]   full_scale_ff, full_scale_in;
   logic               strobe_ff, strobe_in;

   // datapath registers
   logic [LEVEL_W-1:0]   target_ff, target_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   logic [PROD_W-1:0]    product_ff, product_in;
   logic [PWM_W-1:0]     final_ff, final_in;
   logic                 neg_ff, neg_in;
   logic [MAG_W-1:0]     quo_ff, quo_in;
   logic [TICK_BITS-1:0] rem_ff, rem_in;
   logic [DCNT_W-1:0]    div_cnt_ff, div_cnt_in;

   // result registers
   logic [PWM_W-1:0] pwm_ff, pwm_in;
   logic             valid_ff, valid_in;
   logic             done_ff, done_in;
   logic             accepted_ff, accepted_in;

   // table port
   logic               ram_wr_en;
   logic [ENT_W-1:0]   ram_wr_data;
   logic [ENT_W-1:0]   ram_rd_data;
   logic [ACC_W-1:0]   seg_delta;
   logic [TICK_BITS-1:0] seg_ticks;

   // helpers
   logic [DUR_W+TICK_BITS-1:0] dur_ext;
   logic [TICK_BITS-1:0]       dur_mod;
   logic                       table_full;
   logic                       level_high;
   logic [PROD_W-1:0]          round_sum;
   logic [TICK_BITS:0]         rem_shift_t;
   logic [TICK_BITS+1:0]       trial_t;
   logic [ACC_W-1:0]           quo_ext;
   logic [ACC_W:0]             round_acc;
   logic [TICK_BITS-1:0]       tick_next;
   logic                       csr_wr;

   prpp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (play_index_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign seg_delta = ram_rd_data[ENT_W-1:TICK_BITS];
   assign seg_ticks = ram_rd_data[TICK_BITS-1:0];

   // configuration port: one register, combinational read
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_FULL_SCALE);
   assign prdata = (paddr[2] == REG_FULL_SCALE)
                 ? {{(CSR_DATA_W-PWM_W){1'b0}}, full_scale_ff} : '0;

   // duration taken modulo 2^TICK_BITS
   assign dur_ext = {{TICK_BITS{1'b0}}, req_duration_ticks};
   assign dur_mod = dur_ext[TICK_BITS-1:0];

   assign table_full = (write_count_ff >= SEG_LIMIT);
   assign level_high = req_target_level[LEVEL_W-1] &&
                       (req_target_level[LEVEL_W-2:0] != '0);

   // final count rounding: (target * scale + 1/2) >> 16
   assign round_sum = product_ff + {{(PROD_W-PWM_W){1'b0}}, HALF_Q16};

   // shared division step: shift in next dividend bit, trial subtract
   assign rem_shift_t = {rem_ff, quo_ff[MAG_W-1]};
   assign trial_t     = {1'b0, rem_shift_t} - {2'b00, ticks_ff};

   assign quo_ext = {{(ACC_W-MAG_W){1'b0}}, quo_ff};

   // PWM rounding with saturation
   assign round_acc = {acc_ff[ACC_W-1], acc_ff} + {{(ACC_W+1-PWM_W){1'b0}}, HALF_Q16};
   assign tick_next = tick_ff + TICK_BITS'(1);

   assign ram_wr_en   = (state_ff == ST_WRITE);
   assign ram_wr_data = {(neg_ff ? (~quo_ext + ACC_W'(1)) : quo_ext), ticks_ff};

   // sequencer and datapath
   always_comb begin
      state_in       = state_ff;
      write_count_in = write_count_ff;
      play_index_in  = play_index_ff;
      tick_in        = tick_ff;
      acc_in         = acc_ff;
      last_final_in  = last_final_ff;
      full_scale_in  = csr_wr ? pwdata[PWM_W-1:0] : full_scale_ff;
      strobe_in      = 1'b0;
      target_in      = target_ff;
      ticks_in       = ticks_ff;
      product_in     = product_ff;
      final_in       = final_ff;
      neg_in         = neg_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      pwm_in         = pwm_ff;
      valid_in       = valid_ff;
      done_in        = done_ff;
      accepted_in    = accepted_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pwm_in      = '0;
               valid_in    = 1'b0;
               done_in     = 1'b0;
               accepted_in = 1'b0;
               target_in   = req_target_level;
               ticks_in    = (dur_mod == '0) ? TICK_BITS'(1) : dur_mod;
               final_in    = last_final_ff;
               neg_in      = 1'b0;
               quo_in      = '0;
               case (req_op)
                  OP_RAMP: begin
                     if (table_full || level_high) begin
                        strobe_in = 1'b1;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  OP_HOLD: begin
                     if (table_full) begin
                        strobe_in = 1'b1;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  OP_RESTART: begin
                     play_index_in = '0;
                     tick_in       = '0;
                     acc_in        = '0;
                     strobe_in     = 1'b1;
                  end
                  OP_TICK: begin
                     if (play_index_ff >= write_count_ff) begin
                        done_in   = 1'b1;
                        strobe_in = 1'b1;
                     end else begin
                        state_in = ST_TACC;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MUL: begin
            product_in = PROD_W'(target_ff) * PROD_W'(full_scale_ff);
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            final_in = round_sum[PWM_W*2-1:PWM_W];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in     = (final_ff < last_final_ff);
            quo_in     = (final_ff < last_final_ff)
                       ? {last_final_ff - final_ff, {PWM_W{1'b0}}}
                       : {final_ff - last_final_ff, {PWM_W{1'b0}}};
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!trial_t[TICK_BITS+1]) begin
               rem_in = trial_t[TICK_BITS-1:0];
               quo_in = {quo_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift_t[TICK_BITS-1:0];
               quo_in = {quo_ff[MAG_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            write_count_in = write_count_ff + CNT_W'(1);
            last_final_in  = final_ff;
            accepted_in    = 1'b1;
            strobe_in      = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_TACC: begin
            acc_in = acc_ff + seg_delta;
            if (tick_next == seg_ticks) begin
               play_index_in = play_index_ff + CNT_W'(1);
               tick_in       = '0;
            end else begin
               tick_in = tick_next;
            end
            state_in = ST_TOUT;
         end
         ST_TOUT: begin
            if (round_acc[ACC_W]) begin
               pwm_in = '0;
            end else if (round_acc[ACC_W-1:PWM_W*2] != '0) begin
               pwm_in = '1;
            end else begin
               pwm_in = round_acc[PWM_W*2-1:PWM_W];
            end
            valid_in  = 1'b1;
            done_in   = (play_index_ff == write_count_ff);
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         write_count_ff <= '0;
         play_index_ff  <= '0;
         tick_ff        <= '0;
         acc_ff         <= '0;
         last_final_ff  <= '0;
         full_scale_ff  <= FULL_SCALE_RESET;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_count_ff <= write_count_in;
         play_index_ff  <= play_index_in;
         tick_ff        <= tick_in;
         acc_ff         <= acc_in;
         last_final_ff  <= last_final_in;
         full_scale_ff  <= full_scale_in;
         strobe_ff      <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      ticks_ff    <= ticks_in;
      product_ff  <= product_in;
      final_ff    <= final_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      pwm_ff      <= pwm_in;
      valid_ff    <= valid_in;
      done_ff     <= done_in;
      accepted_ff <= accepted_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_pwm_value    = pwm_ff;
   assign rsp_value_valid  = valid_ff;
   assign rsp_profile_done = done_ff;
   assign rsp_accepted     = accepted_ff;

endmodule
